// ----- src/bmt_pkg.sv -----
// Shared types and constants for the breakpoint match table.
// Holds the transaction structs, operation and status codes, and the
// command and status groups between the controller and the datapath.
`default_nettype none

package bmt_pkg;

	// Operation codes.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// Saturation value of a hit counter.
	localparam logic [31:0] HIT_MAX = 32'hFFFF_FFFF;

	// Input transaction.
	typedef struct packed {
		logic [1:0]         op;
		logic [1:0]         event_type;
		logic signed [31:0] step_value;
		logic [4:0]         slot_index;
	} req_t;

	// Result transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic        matched;
		logic [4:0]  slot_out;
		logic [31:0] hits_out;
		logic        paused_out;
		logic [5:0]  entries_out;
	} rsp_t;

	// One table entry as stored in the memory.
	typedef struct packed {
		logic [1:0]  etype;
		logic [31:0] step;
		logic [31:0] hits;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic add_wr;
		logic set_full;
		logic set_ign;
		logic scan_init;
		logic scan_run;
		logic shift_wr;
		logic hit_wr;
		logic rem_dec;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       idx_bad;
		logic       issue;
		logic       vld_s1;
		logic       match;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- src/bmt_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Standalone; no package dependencies.
`default_nettype none

module bmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- src/bmt_datapath.sv -----
// Datapath of the breakpoint match table: entry memory, scan pointer,
// entry count, paused flag and result registers. Uses bmt_pkg and bmt_ram.
`default_nettype none

module bmt_datapath #(
	parameter int SLOTS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bmt_pkg::req_t     req,
	input  wire bmt_pkg::ctl_cmd_t cmd,
	output bmt_pkg::dp_sts_t       sts,
	output bmt_pkg::rsp_t          rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	bmt_pkg::req_t   req_q;
	logic [CW-1:0]   count_q;
	logic            paused_q;
	logic [CW-1:0]   rd_idx_q;
	logic            vld_s1;
	logic [CW-1:0]   idx_s1;
	logic [1:0]      status_q;
	logic            matched_q;
	logic [4:0]      slot_q;
	logic [31:0]     hits_q;

	logic [XW-1:0]   cnt_x;
	logic [XW-1:0]   idx_x;
	logic [XW-1:0]   hit_x;
	logic [CW-1:0]   prev_idx;
	logic            full;
	logic            idx_bad;
	logic            issue;
	logic            step_hit;
	logic            match;
	logic [31:0]     hits_inc;
	bmt_pkg::entry_t rd_entry;
	bmt_pkg::entry_t wr_entry;
	logic [bmt_pkg::ENTRY_W-1:0] rdata;
	logic            we;
	logic [AW-1:0]   waddr;

	// Widened views for comparisons and for the narrow result fields.
	assign cnt_x    = XW'(count_q);
	assign idx_x    = XW'(req_q.slot_index);
	assign hit_x    = XW'(idx_s1);
	assign prev_idx = idx_s1 - CW'(1);

	assign full    = (count_q >= CW'(SLOTS));
	assign idx_bad = (idx_x >= cnt_x);
	assign issue   = (rd_idx_q < count_q);

	// Match test on the entry read in the previous cycle.
	assign rd_entry = bmt_pkg::entry_t'(rdata);
	assign step_hit = rd_entry.step[31] || (rd_entry.step == $unsigned(req_q.step_value));
	assign match    = vld_s1 && (rd_entry.etype == req_q.event_type) && step_hit;
	assign hits_inc = (rd_entry.hits == bmt_pkg::HIT_MAX) ? rd_entry.hits
		: rd_entry.hits + 32'd1;

	// Memory write selection: append, shift down, or hit counter update.
	always_comb begin
		we       = 1'b0;
		waddr    = '0;
		wr_entry = rd_entry;
		if (cmd.add_wr) begin
			we             = 1'b1;
			waddr          = count_q[AW-1:0];
			wr_entry.etype = req_q.event_type;
			wr_entry.step  = $unsigned(req_q.step_value);
			wr_entry.hits  = '0;
		end else if (cmd.shift_wr) begin
			we    = 1'b1;
			waddr = prev_idx[AW-1:0];
		end else if (cmd.hit_wr) begin
			we            = 1'b1;
			waddr         = idx_s1[AW-1:0];
			wr_entry.hits = hits_inc;
		end
	end

	bmt_ram #(
		.WIDTH(bmt_pkg::ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Control state: entry count, paused flag and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			paused_q <= 1'b0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (cmd.add_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.hit_wr) begin
				paused_q <= 1'b1;
			end
			if (cmd.scan_init) begin
				rd_idx_q <= (req_q.op == bmt_pkg::OP_REMOVE) ? CW'(idx_x + XW'(1)) : '0;
				vld_s1   <= 1'b0;
			end else if (cmd.scan_run) begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				vld_s1 <= issue;
			end
		end
	end

	// Payload registers: captured transaction, read index and result fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req;
			status_q  <= bmt_pkg::ST_OK;
			matched_q <= 1'b0;
			slot_q    <= '0;
			hits_q    <= '0;
		end
		if (cmd.scan_run) begin
			idx_s1 <= rd_idx_q;
		end
		if (cmd.set_full) begin
			status_q <= bmt_pkg::ST_FULL;
		end
		if (cmd.set_ign) begin
			status_q <= bmt_pkg::ST_IGNORED;
		end
		if (cmd.add_wr) begin
			slot_q <= cnt_x[4:0];
		end
		if (cmd.hit_wr) begin
			matched_q <= 1'b1;
			slot_q    <= hit_x[4:0];
			hits_q    <= hits_inc;
		end
	end

	// Status toward the controller and the result transaction.
	assign sts.op      = req_q.op;
	assign sts.full    = full;
	assign sts.idx_bad = idx_bad;
	assign sts.issue   = issue;
	assign sts.vld_s1  = vld_s1;
	assign sts.match   = match;

	assign rsp.status      = status_q;
	assign rsp.matched     = matched_q;
	assign rsp.slot_out    = slot_q;
	assign rsp.hits_out    = hits_q;
	assign rsp.paused_out  = paused_q;
	assign rsp.entries_out = cnt_x[5:0];

	// The table never holds more entries than it has slots.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("entry count exceeds table size");

	// A hit counter update only follows a valid read of a matching entry.
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_wr |-> match)
		else $error("hit update without a matching entry");

	// At most one memory write source is active, and append never overflows.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_wr, cmd.shift_wr, cmd.hit_wr}) && !(cmd.add_wr && full))
		else $error("conflicting or overflowing table write");

endmodule

`default_nettype wire

// ----- src/bmt_ctrl.sv -----
// Controller of the breakpoint match table: sequences add, remove and check.
// Uses bmt_pkg for the command and status groups and the operation codes.
`default_nettype none

module bmt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire bmt_pkg::dp_sts_t sts,
	output bmt_pkg::ctl_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DSP  = 5'b00010,
		S_REM  = 5'b00100,
		S_CHK  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   scan_end;

	// The scan is over once nothing is issued and nothing is in flight.
	assign scan_end = !sts.issue && !sts.vld_s1;

	// Next state and datapath commands.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DSP;
				end
			end
			S_DSP: begin
				unique case (sts.op)
					bmt_pkg::OP_ADD: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
						end else begin
							cmd.add_wr = 1'b1;
						end
						state_nxt = S_FIN;
					end
					bmt_pkg::OP_REMOVE: begin
						if (sts.idx_bad) begin
							cmd.set_ign = 1'b1;
							state_nxt   = S_FIN;
						end else begin
							cmd.scan_init = 1'b1;
							state_nxt     = S_REM;
						end
					end
					bmt_pkg::OP_CHECK: begin
						cmd.scan_init = 1'b1;
						state_nxt     = S_CHK;
					end
					default: begin
						state_nxt = S_FIN;
					end
				endcase
			end
			S_REM: begin
				cmd.scan_run = 1'b1;
				cmd.shift_wr = sts.vld_s1;
				if (scan_end) begin
					cmd.rem_dec = 1'b1;
					state_nxt   = S_FIN;
				end
			end
			S_CHK: begin
				if (sts.match) begin
					cmd.hit_wr = 1'b1;
					state_nxt  = S_FIN;
				end else begin
					cmd.scan_run = 1'b1;
					if (scan_end) begin
						state_nxt = S_FIN;
					end
				end
			end
			S_FIN: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

	// The result strobe lasts one cycle and frees the block right after.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe not followed by idle");

	// An accepted transaction makes the block busy without an immediate result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not start work");

	// Exactly one state bit is set at all times.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register is not one-hot");

endmodule

`default_nettype wire

// ----- src/breakpoint_match_table.sv -----
// Breakpoint match table top level. Add, an ignored remove and the unused op finish
// without a scan; a remove shifts the later entries down and a check stops at the first
// match, both by the one-entry-per-cycle scan through the single read port.
// The next transaction is accepted in the cycle after the strobe. Reset clears the
// entry count and paused flag; entries are not cleared.
`default_nettype none

module breakpoint_match_table #(
	parameter int SLOTS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire bmt_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output bmt_pkg::rsp_t      rsp
);

	bmt_pkg::ctl_cmd_t cmd;
	bmt_pkg::dp_sts_t  sts;

	bmt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	bmt_datapath #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the breakpoint match table.
// Drives add, remove and check transactions through the start/busy handshake, predicts
// every result from its own copy of the table, and depends only on bmt_pkg and the RTL.
module testbench;

	localparam int SLOTS = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic start;
	bmt_pkg::req_t cmd;
	logic busy;
	logic done;
	bmt_pkg::rsp_t rsp;

	// Predicted table contents and flags.
	logic [1:0]  tbl_type [SLOTS];
	logic [31:0] tbl_step [SLOTS];
	logic [31:0] tbl_hits [SLOTS];
	int          tbl_count;
	logic        tbl_paused;

	bmt_pkg::rsp_t pending_rsp [$];
	int   mismatches;
	int   cycle_count;
	bit   idle_on;

	breakpoint_match_table #(.SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(cmd),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Apply one transaction to the predicted table and return the expected result.
	function automatic void apply_table_op(input bmt_pkg::req_t item,
			output bmt_pkg::rsp_t res);
		int  i;
		bit  found;
		res = '0;
		res.status = bmt_pkg::ST_OK;
		found = 1'b0;
		case (item.op)
			bmt_pkg::OP_ADD: begin
				if (tbl_count >= SLOTS) begin
					res.status = bmt_pkg::ST_FULL;
				end else begin
					tbl_type[tbl_count] = item.event_type;
					tbl_step[tbl_count] = item.step_value;
					tbl_hits[tbl_count] = '0;
					res.slot_out = tbl_count[4:0];
					tbl_count++;
				end
			end
			bmt_pkg::OP_REMOVE: begin
				if (int'(item.slot_index) >= tbl_count) begin
					res.status = bmt_pkg::ST_IGNORED;
				end else begin
					// Later entries move down by one slot.
					for (i = int'(item.slot_index); i + 1 < tbl_count; i++) begin
						tbl_type[i] = tbl_type[i + 1];
						tbl_step[i] = tbl_step[i + 1];
						tbl_hits[i] = tbl_hits[i + 1];
					end
					tbl_count--;
				end
			end
			bmt_pkg::OP_CHECK: begin
				// The lowest slot wins; a step with the sign bit set matches any step.
				for (i = 0; i < tbl_count && !found; i++) begin
					if (tbl_type[i] == item.event_type &&
					    (tbl_step[i][31] || tbl_step[i] == item.step_value)) begin
						found = 1'b1;
						if (tbl_hits[i] != bmt_pkg::HIT_MAX)
							tbl_hits[i] = tbl_hits[i] + 32'd1;
						tbl_paused = 1'b1;
						res.matched = 1'b1;
						res.slot_out = i[4:0];
						res.hits_out = tbl_hits[i];
					end
				end
			end
			default: begin
			end
		endcase
		res.paused_out = tbl_paused;
		res.entries_out = tbl_count[5:0];
	endfunction

	// Step values that recur, so that several entries share a step.
	function automatic logic [31:0] pool_step();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'hFFFF_FFFF;
			5: return 32'h0000_0064;
			6: return 32'h0000_3039;
			default: return 32'h0000_FFFF;
		endcase
	endfunction

	// Random transaction weighted by operation; checks mostly aim at stored entries.
	function automatic bmt_pkg::req_t random_req(input int add_pct, input int rem_pct,
			input int chk_pct);
		bmt_pkg::req_t item;
		int   roll;
		int   pick;
		item.op = OP_UNUSED;
		item.event_type = 2'($urandom);
		item.step_value = $urandom;
		item.slot_index = 5'($urandom);
		roll = $urandom_range(99);
		if (roll < add_pct) begin
			item.op = bmt_pkg::OP_ADD;
			pick = $urandom_range(99);
			if (pick < 25)
				item.step_value[31] = 1'b1;
			else if (pick < 65)
				item.step_value = pool_step();
		end else if (roll < add_pct + rem_pct) begin
			item.op = bmt_pkg::OP_REMOVE;
			if (tbl_count > 0 && $urandom_range(99) < 85)
				item.slot_index = 5'($urandom_range(tbl_count - 1));
		end else if (roll < add_pct + rem_pct + chk_pct) begin
			item.op = bmt_pkg::OP_CHECK;
			if (tbl_count > 0 && $urandom_range(99) < 60) begin
				pick = $urandom_range(tbl_count - 1);
				item.event_type = tbl_type[pick];
				if (!tbl_step[pick][31])
					item.step_value = tbl_step[pick];
			end else if ($urandom_range(1) == 1) begin
				item.step_value = pool_step();
			end
		end
		return item;
	endfunction

	// Send one transaction, with an optional gap before it, and record its expected result.
	task automatic issue_cmd(input bmt_pkg::req_t item);
		bmt_pkg::rsp_t want;
		if (idle_on && $urandom_range(99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_table_op(item, want);
		pending_rsp.push_back(want);
	endtask

	task automatic send_fields(input logic [1:0] op, input logic [1:0] etype,
			input logic [31:0] step, input logic [4:0] idx);
		bmt_pkg::req_t item;
		item.op = op;
		item.event_type = etype;
		item.step_value = step;
		item.slot_index = idx;
		issue_cmd(item);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Field extremes, each operation, empty and ignored cases, any-step entries.
	task automatic test_directed();
		idle_on = 1'b1;
		send_fields(bmt_pkg::OP_CHECK, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(bmt_pkg::OP_REMOVE, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 5'd31);
		send_fields(bmt_pkg::OP_ADD, 2'd0, 32'h0000_0000, 5'd31);
		send_fields(bmt_pkg::OP_ADD, 2'd3, 32'h7FFF_FFFF, 5'd0);
		send_fields(bmt_pkg::OP_ADD, 2'd1, 32'h8000_0000, 5'd0);
		send_fields(bmt_pkg::OP_ADD, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd0, 32'h0000_0000, 5'd31);
		send_fields(bmt_pkg::OP_CHECK, 2'd3, 32'h7FFF_FFFF, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd3, 32'h7FFF_FFFE, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd1, 32'h8000_0000, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd1, 32'h0000_3039, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd2, 32'hFFFF_FFFF, 5'd0);
		send_fields(bmt_pkg::OP_REMOVE, 2'd0, 32'h0000_0000, 5'd4);
		send_fields(bmt_pkg::OP_REMOVE, 2'd3, 32'hFFFF_FFFF, 5'd31);
		send_fields(bmt_pkg::OP_REMOVE, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(OP_UNUSED, 2'd0, 32'h0000_0000, 5'd0);
		send_fields(bmt_pkg::OP_REMOVE, 2'd0, 32'h0000_0000, 5'd2);
		send_fields(bmt_pkg::OP_ADD, 2'd2, 32'hFFFF_FFFB, 5'd0);
		send_fields(bmt_pkg::OP_CHECK, 2'd2, 32'h8000_0000, 5'd0);
	endtask

	// Fill the table past full several times, then empty it again.
	task automatic test_fill_drain();
		bmt_pkg::req_t item;
		int   full_hits;
		repeat (3) begin
			full_hits = 0;
			while (tbl_count < SLOTS || full_hits < 3) begin
				item = random_req(70, 8, 20);
				if (item.op == bmt_pkg::OP_ADD && tbl_count == SLOTS)
					full_hits++;
				issue_cmd(item);
			end
			while (tbl_count != 0)
				issue_cmd(random_req(10, 65, 23));
		end
	endtask

	// Balanced traffic, starting with a long stretch without gaps.
	task automatic test_mixed_traffic();
		idle_on = 1'b0;
		repeat (120) issue_cmd(random_req(35, 25, 38));
		idle_on = 1'b1;
		repeat (210) issue_cmd(random_req(35, 25, 38));
	endtask

	// Compare every result strobe against the oldest pending transaction.
	always @(posedge clk) begin : check_results
		bmt_pkg::rsp_t want;
		if (done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with no transaction pending, actual %0h", $time, rsp);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				compare_field("status", 32'(want.status), 32'(rsp.status));
				compare_field("matched", 32'(want.matched), 32'(rsp.matched));
				compare_field("slot_out", 32'(want.slot_out), 32'(rsp.slot_out));
				compare_field("hits_out", want.hits_out, rsp.hits_out);
				compare_field("paused_out", 32'(want.paused_out), 32'(rsp.paused_out));
				compare_field("entries_out", 32'(want.entries_out), 32'(rsp.entries_out));
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("breakpoint_match_table verification failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		mismatches = 0;
		idle_on = 1'b1;
		tbl_count = 0;
		tbl_paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain();
		test_mixed_traffic();

		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("breakpoint_match_table verification clean");
		else
			$display("breakpoint_match_table verification failed");
		$finish;
	end

endmodule
